// ===== hdl/wsr_pkg.sv =====
`default_nettype none
package wsr_pkg;

	localparam int unsigned LENGTH_BITS_DEF = 64;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [31:0] MAX_LEN_RESET = 32'd64 << 20;

	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;

	localparam logic [6:0] LEN_CODE16 = 7'd126;
	localparam logic [6:0] LEN_CODE64 = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [2:0] KEY_BYTES   = 3'd4;

	localparam logic [1:0] STOP_NONE  = 2'd0;
	localparam logic [1:0] STOP_CLOSE = 2'd1;
	localparam logic [1:0] STOP_LIMIT = 2'd2;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_PING = 1'b1;

	typedef enum logic [4:0] {
		PH_HDR0 = 5'b00001,
		PH_HDR1 = 5'b00010,
		PH_EXT  = 5'b00100,
		PH_KEY  = 5'b01000,
		PH_PAY  = 5'b10000
	} phase_t;

	// result as queued by the parser; the back end applies the mask
	typedef struct packed {
		logic       has_byte;
		logic [7:0] raw_byte;
		logic [7:0] key_byte;
		logic       stream_kind;
		logic       last;
		logic [1:0] stop_code;
	} res_t;

	localparam int unsigned RES_W = $bits(res_t);

endpackage
`default_nettype wire

// ===== hdl/wsr_fifo.sv =====
`default_nettype none
module wsr_fifo
	import wsr_pkg::*;
#(
	parameter int unsigned WIDTH = RES_W,
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  full,
	output logic                  empty
);
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers wrap at DEPTH so any depth works
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/wsr_front.sv =====
`default_nettype none
module wsr_front
	import wsr_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [31:0] max_len,
	output logic             push,
	output res_t             push_res
);
	localparam int unsigned LB = LENGTH_BITS;

	phase_t        phase_q, phase_d;
	logic          fin_q, fin_d;
	logic [3:0]    kind_q, kind_d;
	logic          mask_q, mask_d;
	logic [LB-1:0] len_q, len_d;
	logic [3:0]    len_left_q, len_left_d;
	logic [31:0]   key_q, key_d;
	logic [2:0]    key_left_q, key_left_d;
	logic [LB-1:0] pay_left_q, pay_left_d;
	logic [1:0]    mphase_q, mphase_d;
	logic          halted_q, halted_d;
	logic          ovf_q, ovf_d;

	logic          len_done, start_pay, pay_end;
	logic [7:0]    key_byte;

	always_comb begin
		unique case (mphase_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		fin_d      = fin_q;
		kind_d     = kind_q;
		mask_d     = mask_q;
		len_d      = len_q;
		len_left_d = len_left_q;
		key_d      = key_q;
		key_left_d = key_left_q;
		pay_left_d = pay_left_q;
		mphase_d   = mphase_q;
		halted_d   = halted_q;
		ovf_d      = ovf_q;
		len_done   = 1'b0;
		start_pay  = 1'b0;
		pay_end    = 1'b0;
		push       = 1'b0;
		push_res   = '0;

		if (take && !halted_q) begin
			unique case (phase_q)
				PH_HDR1: begin
					mask_d = rx_byte[7];
					key_d  = '0;
					ovf_d  = 1'b0;
					len_d  = '0;
					if (rx_byte[6:0] == LEN_CODE16) begin
						len_left_d = EXT16_BYTES;
						phase_d    = PH_EXT;
					end else if (rx_byte[6:0] == LEN_CODE64) begin
						len_left_d = EXT64_BYTES;
						phase_d    = PH_EXT;
					end else begin
						len_d    = LB'(rx_byte[6:0]);
						len_done = 1'b1;
					end
				end
				PH_EXT: begin
					// bits about to shift out of the register count as too long
					ovf_d = ovf_q | (|len_q[LB-1 -: 8]);
					len_d = {len_q[LB-9:0], rx_byte};
					if (len_left_q <= 4'd1) begin
						len_left_d = '0;
						len_done   = 1'b1;
					end else begin
						len_left_d = len_left_q - 4'd1;
					end
				end
				PH_KEY: begin
					key_d = {key_q[23:0], rx_byte};
					if (key_left_q <= 3'd1) begin
						key_left_d = '0;
						start_pay  = 1'b1;
					end else begin
						key_left_d = key_left_q - 3'd1;
					end
				end
				PH_PAY: begin
					mphase_d = mphase_q + 2'd1;
					if (pay_left_q != '0) begin
						pay_left_d = pay_left_q - LB'(1);
					end
					pay_end = (pay_left_d == '0);
					if (pay_end) begin
						phase_d = PH_HDR0;
					end
					push_res.raw_byte = rx_byte;
					push_res.key_byte = key_byte;
					if (kind_q <= OP_BINARY) begin
						push                 = 1'b1;
						push_res.has_byte    = 1'b1;
						push_res.stream_kind = KIND_DATA;
						push_res.last        = fin_q & pay_end;
					end else if (kind_q == OP_PING) begin
						push                 = 1'b1;
						push_res.has_byte    = 1'b1;
						push_res.stream_kind = KIND_PING;
						push_res.last        = pay_end;
					end else if (kind_q == OP_CLOSE && pay_end) begin
						halted_d           = 1'b1;
						push               = 1'b1;
						push_res           = '0;
						push_res.stop_code = STOP_CLOSE;
					end
				end
				default: begin
					fin_d   = rx_byte[7];
					kind_d  = rx_byte[3:0];
					phase_d = PH_HDR1;
				end
			endcase

			if (len_done) begin
				if (ovf_d || (len_d > LB'(max_len))) begin
					halted_d           = 1'b1;
					push               = 1'b1;
					push_res.stop_code = STOP_LIMIT;
				end else if (mask_d) begin
					key_left_d = KEY_BYTES;
					phase_d    = PH_KEY;
				end else begin
					start_pay = 1'b1;
				end
			end

			if (start_pay) begin
				mphase_d   = '0;
				pay_left_d = len_d;
				if (len_d != '0) begin
					phase_d = PH_PAY;
				end else begin
					// empty frame: bare end marker or immediate close
					phase_d = PH_HDR0;
					if (kind_q <= OP_BINARY) begin
						push          = fin_q;
						push_res.last = 1'b1;
					end else if (kind_q == OP_PING) begin
						push                 = 1'b1;
						push_res.stream_kind = KIND_PING;
						push_res.last        = 1'b1;
					end else if (kind_q == OP_CLOSE) begin
						halted_d           = 1'b1;
						push               = 1'b1;
						push_res.stop_code = STOP_CLOSE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			fin_q      <= 1'b0;
			kind_q     <= '0;
			mask_q     <= 1'b0;
			len_q      <= '0;
			len_left_q <= '0;
			key_q      <= '0;
			key_left_q <= '0;
			pay_left_q <= '0;
			mphase_q   <= '0;
			halted_q   <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			fin_q      <= fin_d;
			kind_q     <= kind_d;
			mask_q     <= mask_d;
			len_q      <= len_d;
			len_left_q <= len_left_d;
			key_q      <= key_d;
			key_left_q <= key_left_d;
			pay_left_q <= pay_left_d;
			mphase_q   <= mphase_d;
			halted_q   <= halted_d;
			ovf_q      <= ovf_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/wsr_back.sv =====
`default_nettype none
module wsr_back
	import wsr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire res_t       q_res,
	input  wire logic       q_empty,
	output logic            q_pop,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic            has_byte,
	output logic [7:0]      data_byte,
	output logic            stream_kind,
	output logic            last,
	output logic [1:0]      stop_code
);
	logic       valid_q;
	logic       has_q;
	logic [7:0] data_q;
	logic       kind_q;
	logic       last_q;
	logic [1:0] stop_q;

	// refill the output register when it is empty or its transfer completes
	assign q_pop = !q_empty && (!valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !res_stall) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			has_q  <= q_res.has_byte;
			data_q <= q_res.has_byte ? (q_res.raw_byte ^ q_res.key_byte) : 8'd0;
			kind_q <= q_res.stream_kind;
			last_q <= q_res.last;
			stop_q <= q_res.stop_code;
		end
	end

	assign res_valid   = valid_q;
	assign has_byte    = has_q;
	assign data_byte   = data_q;
	assign stream_kind = kind_q;
	assign last        = last_q;
	assign stop_code   = stop_q;

endmodule
`default_nettype wire

// ===== hdl/websocket_frame_receiver.sv =====
// WebSocket frame receiver.
// Input channel: one received byte per transfer on rx_byte (rx_valid/rx_stall).
// Output channel: one result per transfer (res_valid/res_stall) carrying
// has_byte, data_byte (unmasked), stream_kind (0 message, 1 ping payload),
// last and stop_code (1 close received, 2 length over limit).
// Configuration: APB register 0 at address 0 holds max_payload_length.
// Throughput: one byte per cycle while the result queue is not full; the
// header/length/key/payload parser advances one byte per cycle, and each
// byte yields at most one result. The parser writes the queue at the
// accepting edge; the output register loads from the queue when it is empty
// or its transfer completes.
// rx_stall rises only when the result queue (QUEUE_DEPTH entries) is full,
// which happens when res_stall is held long enough; bytes without a result
// are still absorbed while the queue has room.
// After a close frame or an oversized length the block keeps accepting bytes
// but drops them until reset. Reset returns the parser to the first header
// byte, empties the queue and restores the 64 MiB length limit.
`default_nettype none
module websocket_frame_receiver
	import wsr_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        rx_valid,
	output logic             rx_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             has_byte,
	output logic [7:0]       data_byte,
	output logic             stream_kind,
	output logic             last,
	output logic [1:0]       stop_code
);
	logic [31:0] max_len_q;
	logic        take;
	logic        push;
	res_t        push_res;
	res_t        q_res;
	logic        q_full, q_empty, q_pop;
	logic        reg_sel;

	// paddr[2] selects the register slot; only slot 0 exists
	assign reg_sel = !paddr[2];
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? max_len_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			max_len_q <= pwdata;
		end
	end

	assign rx_stall = q_full;
	assign take     = rx_valid && !q_full;

	wsr_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.rx_byte  (rx_byte),
		.max_len  (max_len_q),
		.push     (push),
		.push_res (push_res)
	);

	wsr_fifo #(
		.WIDTH(RES_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_res),
		.pop     (q_pop),
		.rd_data (q_res),
		.full    (q_full),
		.empty   (q_empty)
	);

	wsr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_res       (q_res),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.has_byte    (has_byte),
		.data_byte   (data_byte),
		.stream_kind (stream_kind),
		.last        (last),
		.stop_code   (stop_code)
	);

endmodule
`default_nettype wire

// ===== test/websocket_frame_receiver_test.sv =====
module websocket_frame_receiver_test;
	timeunit 1ns;
	timeprecision 1ps;
	import wsr_pkg::*;

	localparam logic [3:0] OP_CONT = 4'h0;
	localparam logic [3:0] OP_TEXT = 4'h1;
	localparam logic [3:0] OP_PONG = 4'hA;
	localparam logic [2:0] REG_MAX_LEN = 3'd0;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum logic [1:0] {LEN7, LEN16, LEN64} len_form_t;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] data_byte;
		logic       stream_kind;
		logic       last;
		logic [1:0] stop_code;
	} rx_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        rx_valid = 1'b0;
	logic        rx_stall;
	logic [7:0]  rx_byte = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        has_byte;
	logic [7:0]  data_byte;
	logic        stream_kind;
	logic        last;
	logic [1:0]  stop_code;

	websocket_frame_receiver i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
		.res_valid(res_valid), .res_stall(res_stall),
		.has_byte(has_byte), .data_byte(data_byte), .stream_kind(stream_kind),
		.last(last), .stop_code(stop_code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// deframer state as the block should hold it
	logic [31:0] max_len = MAX_LEN_RESET;
	phase_t      parse_ph = PH_HDR0;
	logic        fin_flag = 1'b0;
	logic [3:0]  opcode = '0;
	logic        masked = 1'b0;
	logic [63:0] len_acc = '0;
	logic [3:0]  len_left = '0;
	logic [31:0] mask_word = '0;
	logic [2:0]  key_left = '0;
	logic [63:0] pay_left = '0;
	logic [1:0]  key_idx = '0;
	logic        stopped = 1'b0;
	logic        len_ovf = 1'b0;

	rx_out_t predicted_out[$];
	rx_out_t got_front;
	int      errors = 0;
	int      bytes_sent = 0;
	int      idle_cycles = 0;
	int      stall_hold = 0;
	int      stall_pick;
	bit      quiet = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_out(input logic has, input logic [7:0] data, input logic kind,
			input logic lst, input logic [1:0] stop);
		rx_out_t item;
		item = '{has, data, kind, lst, stop};
		predicted_out.insert(predicted_out.size(), item);
	endtask

	task automatic open_payload();
		key_idx = '0;
		pay_left = len_acc;
		if (pay_left != 0) begin
			parse_ph = PH_PAY;
			return;
		end
		parse_ph = PH_HDR0;
		if (opcode <= OP_BINARY) begin
			if (fin_flag)
				queue_out(1'b0, 8'd0, KIND_DATA, 1'b1, STOP_NONE);
		end else if (opcode == OP_PING) begin
			queue_out(1'b0, 8'd0, KIND_PING, 1'b1, STOP_NONE);
		end else if (opcode == OP_CLOSE) begin
			stopped = 1'b1;
			queue_out(1'b0, 8'd0, KIND_DATA, 1'b0, STOP_CLOSE);
		end
	endtask

	task automatic close_length();
		if (len_ovf || len_acc > {32'd0, max_len}) begin
			stopped = 1'b1;
			queue_out(1'b0, 8'd0, KIND_DATA, 1'b0, STOP_LIMIT);
		end else if (masked) begin
			key_left = KEY_BYTES;
			parse_ph = PH_KEY;
		end else begin
			open_payload();
		end
	endtask

	task automatic parse_rx_byte(input logic [7:0] b);
		logic [7:0] kb;
		logic [7:0] d;
		logic       at_end;
		if (stopped)
			return;
		case (parse_ph)
			PH_HDR1: begin
				masked = b[7];
				mask_word = '0;
				len_ovf = 1'b0;
				len_acc = '0;
				if (b[6:0] == LEN_CODE16) begin
					len_left = EXT16_BYTES;
					parse_ph = PH_EXT;
				end else if (b[6:0] == LEN_CODE64) begin
					len_left = EXT64_BYTES;
					parse_ph = PH_EXT;
				end else begin
					len_acc = {57'd0, b[6:0]};
					close_length();
				end
			end
			PH_EXT: begin
				if (len_acc[63:56] != 0)
					len_ovf = 1'b1;
				len_acc = {len_acc[55:0], b};
				if (len_left <= 1) begin
					len_left = '0;
					close_length();
				end else begin
					len_left = len_left - 1;
				end
			end
			PH_KEY: begin
				mask_word = {mask_word[23:0], b};
				if (key_left <= 1) begin
					key_left = '0;
					open_payload();
				end else begin
					key_left = key_left - 1;
				end
			end
			PH_PAY: begin
				// first key byte received unmasks payload byte 0
				kb = mask_word[8 * (3 - int'(key_idx)) +: 8];
				d = b ^ kb;
				key_idx = key_idx + 1;
				if (pay_left != 0)
					pay_left = pay_left - 1;
				at_end = (pay_left == 0);
				if (at_end)
					parse_ph = PH_HDR0;
				if (opcode <= OP_BINARY) begin
					queue_out(1'b1, d, KIND_DATA, fin_flag && at_end, STOP_NONE);
				end else if (opcode == OP_PING) begin
					queue_out(1'b1, d, KIND_PING, at_end, STOP_NONE);
				end else if (opcode == OP_CLOSE && at_end) begin
					stopped = 1'b1;
					queue_out(1'b0, 8'd0, KIND_DATA, 1'b0, STOP_CLOSE);
				end
			end
			default: begin
				fin_flag = b[7];
				opcode = b[3:0];
				parse_ph = PH_HDR1;
			end
		endcase
	endtask

	// result side: random stall, sampled values are the pre-edge ones
	always @(posedge clk) begin
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else if (quiet) begin
			res_stall <= 1'b0;
		end else begin
			stall_pick = $urandom_range(0, 99);
			res_stall <= (stall_pick < 35);
			stall_hold <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (predicted_out.size() == 0) begin
				$error("unexpected result: has_byte %0d data_byte %0h stop_code %0d",
					has_byte, data_byte, stop_code);
				errors++;
			end else begin
				got_front = predicted_out.pop_front();
				if (has_byte !== got_front.has_byte) begin
					$error("has_byte: expected %0d, actual %0d", got_front.has_byte, has_byte);
					errors++;
				end
				if (data_byte !== got_front.data_byte) begin
					$error("data_byte: expected %0h, actual %0h", got_front.data_byte, data_byte);
					errors++;
				end
				if (stream_kind !== got_front.stream_kind) begin
					$error("stream_kind: expected %0d, actual %0d", got_front.stream_kind,
						stream_kind);
					errors++;
				end
				if (last !== got_front.last) begin
					$error("last: expected %0d, actual %0d", got_front.last, last);
					errors++;
				end
				if (stop_code !== got_front.stop_code) begin
					$error("stop_code: expected %0d, actual %0d", got_front.stop_code, stop_code);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rx_valid && !rx_stall) || (res_valid && !res_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall);
		bytes_sent++;
		parse_rx_byte(b);
	endtask

	// hold off until every predicted result is out and the pipe is empty
	task automatic wait_drained();
		rx_valid <= 1'b0;
		while (predicted_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == REG_MAX_LEN)
			max_len = data;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_max_len();
		logic [31:0] rd;
		apb_read(REG_MAX_LEN, rd);
		if (rd !== max_len) begin
			$error("max_payload_length: expected %0h, actual %0h", max_len, rd);
			errors++;
		end
	endtask

	task automatic set_max_len(input logic [31:0] value);
		apb_write(REG_MAX_LEN, value);
		@(posedge clk);
		check_max_len();
	endtask

	task automatic send_header(input bit fin, input logic [2:0] rsv, input logic [3:0] op,
			input bit msk, input len_form_t form, input logic [63:0] len,
			input logic [31:0] key);
		logic [6:0] code;
		case (form)
			LEN16: code = LEN_CODE16;
			LEN64: code = LEN_CODE64;
			default: code = len[6:0];
		endcase
		send_byte({fin, rsv, op});
		send_byte({msk, code});
		if (form == LEN16) begin
			send_byte(len[15:8]);
			send_byte(len[7:0]);
		end else if (form == LEN64) begin
			for (int i = 7; i >= 0; i--)
				send_byte(len[8 * i +: 8]);
		end
		if (msk)
			for (int i = 3; i >= 0; i--)
				send_byte(key[8 * i +: 8]);
	endtask

	// fill < 0 gives random payload bytes
	task automatic send_frame(input bit fin, input logic [2:0] rsv, input logic [3:0] op,
			input bit msk, input len_form_t form, input logic [63:0] len,
			input logic [31:0] key, input int fill);
		send_header(fin, rsv, op, msk, form, len, key);
		for (longint unsigned i = 0; i < len; i++)
			send_byte(fill < 0 ? 8'($urandom) : fill[7:0]);
	endtask

	function automatic len_form_t pick_form(input int len);
		int r;
		r = $urandom_range(0, 99);
		if (len > 125)
			return (r < 50) ? LEN16 : LEN64;
		if (r < 70)
			return LEN7;
		if (r < 85)
			return LEN16;
		return LEN64;
	endfunction

	// never a close: that would stop the receiver for good
	function automatic logic [3:0] pick_opcode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 4'($urandom_range(OP_CONT, OP_BINARY));
		if (r < 85)
			return OP_PING;
		if (r < 92)
			return OP_PONG;
		r = $urandom_range(0, 9);
		return (r < 5) ? OP_BINARY + 4'(1 + r) : OP_PONG + 4'(r - 4);
	endfunction

	task automatic random_frame();
		logic [3:0] op;
		logic [2:0] rsv;
		int len;
		int r;
		op = pick_opcode();
		rsv = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'd0;
		r = $urandom_range(0, 99);
		if (r < 15)
			len = 0;
		else if (r < 80)
			len = $urandom_range(1, 12);
		else if (r < 95)
			len = $urandom_range(13, 60);
		else
			len = $urandom_range(126, 200);
		if (len > max_len)
			len = int'(max_len);
		send_frame($urandom_range(0, 3) != 0, rsv, op, $urandom_range(0, 3) != 0,
			pick_form(len), len, $urandom, -1);
	endtask

	task automatic test_reset_limit();
		check_max_len();
	endtask

	task automatic test_frame_types();
		send_frame(1, 3'd0, OP_TEXT, 0, LEN7, 1, 32'd0, 8'h00);
		// mask index wraps past the fourth key byte
		send_frame(1, 3'd0, OP_BINARY, 1, LEN7, 5, 32'hFFFF_FFFF, 8'h00);
		send_frame(1, 3'd0, OP_TEXT, 0, LEN7, 0, 32'd0, -1);
		send_frame(0, 3'd0, OP_BINARY, 1, LEN7, 0, $urandom, -1);
		// ping between fragments of one message
		send_frame(0, 3'd0, OP_TEXT, 1, LEN16, 2, $urandom, -1);
		send_frame(1, 3'd0, OP_PING, 1, LEN7, 3, $urandom, -1);
		send_frame(1, 3'd0, OP_CONT, 0, LEN64, 2, 32'd0, 8'hFF);
		send_frame(1, 3'd0, OP_PING, 0, LEN7, 0, 32'd0, -1);
		send_frame(1, 3'd0, OP_PONG, 1, LEN7, 2, $urandom, -1);
		send_frame(1, 3'd0, OP_BINARY + 4'd1, 0, LEN7, 1, 32'd0, -1);
		send_frame(1, 3'd0, OP_PONG + 4'd5, 1, LEN7, 0, $urandom, -1);
		send_frame(1, 3'b111, OP_TEXT, 1, LEN7, 1, $urandom, -1);
	endtask

	task automatic test_limit_edges();
		logic [3:0] ops [6];
		ops = '{OP_CONT, OP_TEXT, OP_BINARY, OP_PING, OP_PONG, OP_PONG + 4'd5};
		wait_drained();
		set_max_len(32'd0);
		foreach (ops[k])
			send_frame($urandom_range(0, 1), 3'd0, ops[k], $urandom_range(0, 1),
				pick_form(0), 0, $urandom, -1);
		wait_drained();
		set_max_len(32'd3);
		send_frame(1, 3'd0, OP_TEXT, 1, LEN64, 3, $urandom, -1);
		send_frame(1, 3'd0, OP_PING, 0, LEN16, 3, 32'd0, -1);
		send_frame(0, 3'd0, OP_BINARY, 1, LEN7, 2, $urandom, -1);
		send_frame(1, 3'd0, OP_CONT, 0, LEN7, 1, 32'd0, -1);
	endtask

	task automatic run_traffic_phase(input logic [31:0] lim, input int n_bytes);
		int start;
		int frames;
		bit held;
		wait_drained();
		set_max_len(lim);
		start = bytes_sent;
		frames = 0;
		held = 0;
		while (bytes_sent - start < n_bytes) begin
			if (frames % 5 == 0)
				quiet = ($urandom_range(0, 5) == 0);
			if (!held && bytes_sent - start >= n_bytes / 2) begin
				wait_drained();
				held = 1;
			end
			random_frame();
			frames++;
		end
		quiet = 0;
	endtask

	task automatic test_random_traffic();
		run_traffic_phase(32'hFFFF_FFFF, 340);
		run_traffic_phase(32'($urandom_range(300, 32'hFFFF_FFFE)), 340);
		run_traffic_phase(32'd12, 340);
		run_traffic_phase(MAX_LEN_RESET, 340);
	endtask

	// only one stop per run, since reset is never asserted again
	task automatic test_receiver_stop();
		logic [31:0] lim;
		wait_drained();
		case ($urandom_range(0, 3))
			0: begin
				if ($urandom_range(0, 1))
					send_frame(0, 3'd0, OP_TEXT, 1, LEN7, 2, $urandom, -1);
				lim = $urandom_range(0, 5);
				send_frame(1, 3'd0, OP_CLOSE, $urandom_range(0, 1), pick_form(lim), lim,
					$urandom, -1);
			end
			1: begin
				lim = $urandom_range(0, 124);
				set_max_len(lim);
				send_header($urandom_range(0, 1), 3'd0, pick_opcode(), 1, LEN7, lim + 1,
					$urandom);
			end
			2: begin
				lim = $urandom_range(0, 65534);
				set_max_len(lim);
				send_header(1, 3'd0, pick_opcode(), $urandom_range(0, 1), LEN16, lim + 1,
					$urandom);
			end
			default: begin
				set_max_len(32'hFFFF_FFFF);
				send_header(1, 3'd0, pick_opcode(), 1, LEN64,
					$urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h1_0000_0000,
					$urandom);
			end
		endcase
		// everything after the stop is dropped
		repeat (24) send_byte(8'($urandom));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_limit();
		test_frame_types();
		test_limit_edges();
		test_random_traffic();
		test_receiver_stop();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && predicted_out.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
